@@ rtl/core/csr_graph_batch_update_core_assert.svh @@
// Assertion macros shared by the checker of the graph update core.
// Holds only macro definitions; no other dependencies.
`ifndef CSR_GRAPH_BATCH_UPDATE_CORE_ASSERT_SVH
`define CSR_GRAPH_BATCH_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication under reset
`define CGBU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication under reset
`define CGBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/cgbu_pkg.sv @@
// Shared constants, codes and request types of the graph update core.
// No dependencies; imported by every module of the core.
package cgbu_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 8192;
    localparam int BATCH_DEPTH_DEF  = 256;

    localparam int NODE_W    = 10;            // source / target field width
    localparam int NODE_SPAN = 1 << NODE_W;   // reachable source / target values
    localparam int KEY_W     = 2 * NODE_W;    // packed source:target
    localparam int VC_W      = 11;            // vertex limit register width
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 14;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Requests to the touched-row and row-membership bitmaps
    typedef struct packed {
        logic              t_we;
        logic [NODE_W-1:0] t_waddr;
        logic              t_wdata;
        logic [NODE_W-1:0] t_raddr;
        logic              m_we;
        logic [NODE_W-1:0] m_waddr;
        logic              m_wdata;
        logic [NODE_W-1:0] m_raddr;
    } bmp_req_t;

endpackage

@@ rtl/core/cgbu_bitmap.sv @@
// Touched-row bitmap and row-membership bitmap, one bit per vertex each.
// Depends on cgbu_pkg for widths and the request struct.
module cgbu_bitmap
    import cgbu_pkg::*;
(
    input  logic     clk,
    input  bmp_req_t req,
    output logic     t_rdata,
    output logic     m_rdata
);

    logic touched_mem [NODE_SPAN];
    logic member_mem  [NODE_SPAN];
    logic t_rd_reg;
    logic m_rd_reg;

    // Touched rows: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (req.t_we)
        begin
            touched_mem[req.t_waddr] <= req.t_wdata;
        end
        t_rd_reg <= touched_mem[req.t_raddr];
    end

    // Membership: read returns the old value when read and write hit the same bit
    always_ff @(posedge clk)
    begin
        if (req.m_we)
        begin
            member_mem[req.m_waddr] <= req.m_wdata;
        end
        m_rd_reg <= member_mem[req.m_raddr];
    end

    assign t_rdata = t_rd_reg;
    assign m_rdata = m_rd_reg;

endmodule

@@ rtl/core/cgbu_batch.sv @@
// Pending insertion and deletion lists with their fill counts.
// Depends on cgbu_pkg for the key width.
module cgbu_batch
    import cgbu_pkg::*;
#(
    parameter int BATCH_DEPTH = BATCH_DEPTH_DEF,
    localparam int CW  = $clog2(BATCH_DEPTH + 1),
    localparam int BIW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_ins,
    input  logic             push_del,
    input  logic [KEY_W-1:0] push_key,
    input  logic             clear,
    input  logic             rd_sel,      // 0 deletions, 1 insertions
    input  logic [BIW-1:0]   rd_idx,
    output logic [KEY_W-1:0] rd_key,
    output logic [CW-1:0]    ins_count,
    output logic [CW-1:0]    del_count
);

    logic [KEY_W-1:0] ins_mem [BATCH_DEPTH];
    logic [KEY_W-1:0] del_mem [BATCH_DEPTH];
    logic [KEY_W-1:0] rd_key_reg;
    logic [CW-1:0]    ins_count_reg, ins_count_next;
    logic [CW-1:0]    del_count_reg, del_count_next;

    // Append at the fill count; registered read of the selected list
    always_ff @(posedge clk)
    begin
        if (push_ins)
        begin
            ins_mem[ins_count_reg[BIW-1:0]] <= push_key;
        end
        if (push_del)
        begin
            del_mem[del_count_reg[BIW-1:0]] <= push_key;
        end
        rd_key_reg <= rd_sel ? ins_mem[rd_idx] : del_mem[rd_idx];
    end

    always_comb
    begin
        ins_count_next = ins_count_reg;
        del_count_next = del_count_reg;
        if (clear)
        begin
            ins_count_next = '0;
            del_count_next = '0;
        end
        else
        begin
            if (push_ins)
            begin
                ins_count_next = ins_count_reg + CW'(1);
            end
            if (push_del)
            begin
                del_count_next = del_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ins_count_reg <= '0;
            del_count_reg <= '0;
        end
        else
        begin
            ins_count_reg <= ins_count_next;
            del_count_reg <= del_count_next;
        end
    end

    assign rd_key    = rd_key_reg;
    assign ins_count = ins_count_reg;
    assign del_count = del_count_reg;

endmodule

@@ rtl/core/cgbu_store.sv @@
// Double-banked row offsets and neighbor lists of the committed graph.
// Reads come from the active bank, writes go to the shadow bank. Uses cgbu_pkg.
module cgbu_store
    import cgbu_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    localparam int RW = $clog2(MAX_VERTICES + 1),
    localparam int OW = $clog2(MAX_EDGES + 1),
    localparam int AW = $clog2(MAX_EDGES)
)
(
    input  logic              clk,
    input  logic              bank_sel,   // active bank
    input  logic [RW-1:0]     off_raddr,
    output logic [OW-1:0]     off_rdata,
    input  logic              off_we,
    input  logic [RW-1:0]     off_waddr,
    input  logic [OW-1:0]     off_wdata,
    input  logic [AW-1:0]     nb_raddr,
    output logic [NODE_W-1:0] nb_rdata,
    input  logic              nb_we,
    input  logic [AW-1:0]     nb_waddr,
    input  logic [NODE_W-1:0] nb_wdata
);

    logic [OW-1:0]     off0_mem [MAX_VERTICES + 1];
    logic [OW-1:0]     off1_mem [MAX_VERTICES + 1];
    logic [NODE_W-1:0] nb0_mem  [MAX_EDGES];
    logic [NODE_W-1:0] nb1_mem  [MAX_EDGES];
    logic [OW-1:0]     off0_rd_reg, off1_rd_reg;
    logic [NODE_W-1:0] nb0_rd_reg, nb1_rd_reg;

    // Offset banks
    always_ff @(posedge clk)
    begin
        if (off_we && bank_sel)
        begin
            off0_mem[off_waddr] <= off_wdata;
        end
        off0_rd_reg <= off0_mem[off_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (off_we && !bank_sel)
        begin
            off1_mem[off_waddr] <= off_wdata;
        end
        off1_rd_reg <= off1_mem[off_raddr];
    end

    // Neighbor banks
    always_ff @(posedge clk)
    begin
        if (nb_we && bank_sel)
        begin
            nb0_mem[nb_waddr] <= nb_wdata;
        end
        nb0_rd_reg <= nb0_mem[nb_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nb_we && !bank_sel)
        begin
            nb1_mem[nb_waddr] <= nb_wdata;
        end
        nb1_rd_reg <= nb1_mem[nb_raddr];
    end

    assign off_rdata = bank_sel ? off1_rd_reg : off0_rd_reg;
    assign nb_rdata  = bank_sel ? nb1_rd_reg : nb0_rd_reg;

endmodule

@@ rtl/core/csr_graph_batch_update_core.sv @@
// Insert / delete, and a query past the live rows, go from the request straight to the result.
// Other queries fetch the row bounds, then run a binary search over the row.
// Commit clears both bitmaps, marks touched rows, then rebuilds every live row: an
// untouched row is copied, a touched row is merged through the membership bitmap.
// Rows past the live count are then filled.
// One request in flight at a time. Reset (async, active low) empties the graph and batch.
module csr_graph_batch_update_core
    import cgbu_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    parameter int BATCH_DEPTH  = BATCH_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [VC_W-1:0]       cfg_wdata,       // live vertex limit
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,    // source[9:0], target[19:10], zero pad
    input  logic [MODE_W-1:0]     s_axis_tuser,    // mode[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata     // found[0], status[2:1], edge_total[16:3]
);

    localparam int RW  = $clog2(MAX_VERTICES + 1);
    localparam int OW  = $clog2(MAX_EDGES + 1);
    localparam int AW  = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(BATCH_DEPTH + 1);
    localparam int BIW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
    localparam int SW  = NODE_W + 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DONE   = 5'd1;
    localparam logic [4:0] S_QB     = 5'd2;
    localparam logic [4:0] S_QE     = 5'd3;
    localparam logic [4:0] S_QS     = 5'd4;
    localparam logic [4:0] S_QW     = 5'd5;
    localparam logic [4:0] S_QC     = 5'd6;
    localparam logic [4:0] S_CCLR   = 5'd7;
    localparam logic [4:0] S_CMK    = 5'd8;
    localparam logic [4:0] S_RSTART = 5'd9;
    localparam logic [4:0] S_RROW   = 5'd10;
    localparam logic [4:0] S_RGET   = 5'd11;
    localparam logic [4:0] S_RCOPY  = 5'd12;
    localparam logic [4:0] S_RMARK  = 5'd13;
    localparam logic [4:0] S_RLST   = 5'd14;
    localparam logic [4:0] S_RSWP   = 5'd15;
    localparam logic [4:0] S_REND   = 5'd16;
    localparam logic [4:0] S_FILL   = 5'd17;

    // Control and payload registers
    logic [4:0]          state_reg, state_next;
    logic [VC_W-1:0]     vcount_reg;
    logic                bank_reg, bank_next;
    logic                empty_reg, empty_next;
    logic [OW-1:0]       total_reg, total_next;
    logic [NODE_W-1:0]   src_reg, src_next;
    logic [NODE_W-1:0]   tgt_reg, tgt_next;
    logic [OW-1:0]       b_reg, b_next;
    logic [OW-1:0]       e_reg, e_next;
    logic [OW-1:0]       lo_reg, lo_next;
    logic [OW-1:0]       hi_reg, hi_next;
    logic [OW-1:0]       mid_reg, mid_next;
    logic [RW-1:0]       v_reg, v_next;
    logic [OW-1:0]       pos_reg, pos_next;
    logic [OW-1:0]       k_reg, k_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                sel_reg, sel_next;
    logic [SW-1:0]       sweep_reg, sweep_next;
    logic                pv_reg, pv_next;
    logic [NODE_W-1:0]   ptag_reg, ptag_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;

    // Memory-side signals
    logic [RW-1:0]       off_raddr, off_waddr;
    logic [OW-1:0]       off_rdata, off_wdata, off_eff;
    logic                off_we;
    logic [AW-1:0]       nb_raddr, nb_waddr;
    logic [NODE_W-1:0]   nb_rdata, nb_wdata;
    logic                nb_we;
    bmp_req_t            bmp_req;
    logic                t_rdata, m_rdata;
    logic                push_ins, push_del, batch_clear;
    logic [KEY_W-1:0]    rd_key;
    logic [CW-1:0]       ins_count, del_count, list_count;

    // Derived values
    logic [RW-1:0]       v_live;
    logic                accept;
    logic [NODE_W-1:0]   in_src, in_tgt;
    logic [NODE_W-1:0]   key_src, key_tgt;
    logic [OW-1:0]       mid_calc;

    cgbu_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_store (
        .clk       (clk),
        .bank_sel  (bank_reg),
        .off_raddr (off_raddr),
        .off_rdata (off_rdata),
        .off_we    (off_we),
        .off_waddr (off_waddr),
        .off_wdata (off_wdata),
        .nb_raddr  (nb_raddr),
        .nb_rdata  (nb_rdata),
        .nb_we     (nb_we),
        .nb_waddr  (nb_waddr),
        .nb_wdata  (nb_wdata)
    );

    cgbu_batch #(
        .BATCH_DEPTH (BATCH_DEPTH)
    ) u_batch (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_ins  (push_ins),
        .push_del  (push_del),
        .push_key  ({in_src, in_tgt}),
        .clear     (batch_clear),
        .rd_sel    (sel_reg),
        .rd_idx    (idx_reg[BIW-1:0]),
        .rd_key    (rd_key),
        .ins_count (ins_count),
        .del_count (del_count)
    );

    cgbu_bitmap u_bitmap (
        .clk     (clk),
        .req     (bmp_req),
        .t_rdata (t_rdata),
        .m_rdata (m_rdata)
    );

    assign in_src   = s_axis_tdata[NODE_W-1:0];
    assign in_tgt   = s_axis_tdata[2*NODE_W-1:NODE_W];
    assign key_src  = rd_key[KEY_W-1:NODE_W];
    assign key_tgt  = rd_key[NODE_W-1:0];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign off_eff  = empty_reg ? '0 : off_rdata;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign list_count = sel_reg ? ins_count : del_count;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - TOTAL_W - STATUS_W - 1){1'b0}},
                            out_total_reg, out_status_reg, out_found_reg};

    // Live vertex count, clamped to the row capacity
    always_comb
    begin
        if (32'(vcount_reg) >= MAX_VERTICES)
        begin
            v_live = RW'(MAX_VERTICES);
        end
        else
        begin
            v_live = RW'(vcount_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        empty_next  = empty_reg;
        total_next  = total_reg;
        src_next    = src_reg;
        tgt_next    = tgt_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        v_next      = v_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        sel_next    = sel_reg;
        sweep_next  = sweep_reg;
        pv_next     = 1'b0;
        ptag_next   = ptag_reg;
        found_next  = found_reg;
        status_next = status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;

        off_raddr   = RW'(src_reg);
        off_we      = 1'b0;
        off_waddr   = '0;
        off_wdata   = pos_reg;
        nb_raddr    = AW'(k_reg);
        nb_we       = 1'b0;
        nb_waddr    = AW'(pos_reg);
        nb_wdata    = nb_rdata;
        bmp_req     = '0;
        push_ins    = 1'b0;
        push_del    = 1'b0;
        batch_clear = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    src_next    = in_src;
                    tgt_next    = in_tgt;
                    found_next  = 1'b0;
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                    case (s_axis_tuser)
                        MODE_QUERY:
                        begin
                            if (32'(in_src) < 32'(v_live))
                            begin
                                off_raddr  = RW'(in_src);
                                state_next = S_QB;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (ins_count == CW'(BATCH_DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                push_ins = 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (del_count == CW'(BATCH_DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                push_del = 1'b1;
                            end
                        end
                        default:
                        begin
                            sweep_next = '0;
                            state_next = S_CCLR;
                        end
                    endcase
                end
            end

            // Query: fetch row bounds, then binary search
            S_QB:
            begin
                b_next     = off_eff;
                off_raddr  = RW'(src_reg) + RW'(1);
                state_next = S_QE;
            end
            S_QE:
            begin
                e_next     = off_eff;
                lo_next    = b_reg;
                hi_next    = off_eff;
                state_next = S_QS;
            end
            S_QS:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    nb_raddr   = AW'(mid_calc);
                    state_next = S_QW;
                end
                else if (lo_reg < e_reg)
                begin
                    nb_raddr   = AW'(lo_reg);
                    state_next = S_QC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_QW:
            begin
                if (nb_rdata < tgt_reg)
                begin
                    lo_next = mid_reg + OW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_QS;
            end
            S_QC:
            begin
                found_next = (nb_rdata == tgt_reg);
                state_next = S_DONE;
            end

            // Commit: clear both bitmaps
            S_CCLR:
            begin
                bmp_req.t_we    = 1'b1;
                bmp_req.t_waddr = NODE_W'(sweep_reg);
                bmp_req.m_we    = 1'b1;
                bmp_req.m_waddr = NODE_W'(sweep_reg);
                sweep_next      = sweep_reg + SW'(1);
                if (32'(sweep_reg) == NODE_SPAN - 1)
                begin
                    idx_next   = '0;
                    sel_next   = 1'b0;
                    state_next = S_CMK;
                end
            end

            // Mark touched rows from deletions, then insertions
            S_CMK:
            begin
                if (idx_reg < list_count)
                begin
                    idx_next = idx_reg + CW'(1);
                    pv_next  = 1'b1;
                end
                if (pv_reg && (32'(key_src) < 32'(v_live)))
                begin
                    bmp_req.t_we    = 1'b1;
                    bmp_req.t_waddr = key_src;
                    bmp_req.t_wdata = 1'b1;
                end
                if (idx_reg >= list_count && !pv_reg)
                begin
                    idx_next = '0;
                    if (sel_reg)
                    begin
                        state_next = S_RSTART;
                    end
                    else
                    begin
                        sel_next = 1'b1;
                    end
                end
            end

            S_RSTART:
            begin
                off_we     = 1'b1;
                off_waddr  = '0;
                off_wdata  = '0;
                v_next     = '0;
                pos_next   = '0;
                b_next     = '0;
                state_next = S_RROW;
            end

            // Next live row: read its end offset and touched bit
            S_RROW:
            begin
                if (v_reg < v_live)
                begin
                    off_raddr       = v_reg + RW'(1);
                    bmp_req.t_raddr = NODE_W'(v_reg);
                    state_next      = S_RGET;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_RGET:
            begin
                e_next = off_eff;
                k_next = b_reg;
                if (t_rdata && (32'(v_reg) < NODE_SPAN))
                begin
                    state_next = S_RMARK;
                end
                else
                begin
                    state_next = S_RCOPY;
                end
            end

            // Untouched row: straight copy into the shadow bank
            S_RCOPY:
            begin
                if (k_reg < e_reg)
                begin
                    k_next  = k_reg + OW'(1);
                    pv_next = 1'b1;
                end
                if (pv_reg)
                begin
                    if (pos_reg == OW'(MAX_EDGES))
                    begin
                        batch_clear = 1'b1;
                        status_next = STATUS_OVERFLOW;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        nb_we    = 1'b1;
                        pos_next = pos_reg + OW'(1);
                    end
                end
                if (k_reg >= e_reg && !pv_reg)
                begin
                    state_next = S_REND;
                end
            end

            // Touched row: base edges into the membership bitmap
            S_RMARK:
            begin
                if (k_reg < e_reg)
                begin
                    k_next  = k_reg + OW'(1);
                    pv_next = 1'b1;
                end
                if (pv_reg)
                begin
                    bmp_req.m_we    = 1'b1;
                    bmp_req.m_waddr = nb_rdata;
                    bmp_req.m_wdata = 1'b1;
                end
                if (k_reg >= e_reg && !pv_reg)
                begin
                    idx_next   = '0;
                    sel_next   = 1'b0;
                    state_next = S_RLST;
                end
            end

            // Apply deletions (clear) then insertions (set) for this row
            S_RLST:
            begin
                if (idx_reg < list_count)
                begin
                    idx_next = idx_reg + CW'(1);
                    pv_next  = 1'b1;
                end
                if (pv_reg && (32'(key_src) == 32'(v_reg)))
                begin
                    bmp_req.m_we    = 1'b1;
                    bmp_req.m_waddr = key_tgt;
                    bmp_req.m_wdata = sel_reg;
                end
                if (idx_reg >= list_count && !pv_reg)
                begin
                    idx_next = '0;
                    if (sel_reg)
                    begin
                        sweep_next = '0;
                        state_next = S_RSWP;
                    end
                    else
                    begin
                        sel_next = 1'b1;
                    end
                end
            end

            // Sweep the bitmap in target order, emit set bits and clear every bit
            S_RSWP:
            begin
                if (32'(sweep_reg) < NODE_SPAN)
                begin
                    bmp_req.m_raddr = NODE_W'(sweep_reg);
                    bmp_req.m_we    = 1'b1;
                    bmp_req.m_waddr = NODE_W'(sweep_reg);
                    ptag_next       = NODE_W'(sweep_reg);
                    sweep_next      = sweep_reg + SW'(1);
                    pv_next         = 1'b1;
                end
                if (pv_reg && m_rdata)
                begin
                    if (pos_reg == OW'(MAX_EDGES))
                    begin
                        batch_clear = 1'b1;
                        status_next = STATUS_OVERFLOW;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        nb_we    = 1'b1;
                        nb_wdata = ptag_reg;
                        pos_next = pos_reg + OW'(1);
                    end
                end
                if ((32'(sweep_reg) >= NODE_SPAN) && !pv_reg)
                begin
                    state_next = S_REND;
                end
            end

            S_REND:
            begin
                off_we     = 1'b1;
                off_waddr  = v_reg + RW'(1);
                b_next     = e_reg;
                v_next     = v_reg + RW'(1);
                state_next = S_RROW;
            end

            // Rows past the live count end where the last live row ends
            S_FILL:
            begin
                if (32'(v_reg) < MAX_VERTICES)
                begin
                    off_we    = 1'b1;
                    off_waddr = v_reg + RW'(1);
                    v_next    = v_reg + RW'(1);
                end
                else
                begin
                    bank_next   = !bank_reg;
                    empty_next  = 1'b0;
                    total_next  = pos_reg;
                    batch_clear = 1'b1;
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_total_next  = TOTAL_W'(total_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= '0;
            bank_reg      <= 1'b0;
            empty_reg     <= 1'b1;
            total_reg     <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            empty_reg     <= empty_next;
            total_reg     <= total_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        tgt_reg        <= tgt_next;
        b_reg          <= b_next;
        e_reg          <= e_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        v_reg          <= v_next;
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        idx_reg        <= idx_next;
        sel_reg        <= sel_next;
        sweep_reg      <= sweep_next;
        ptag_reg       <= ptag_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
    end

endmodule

@@ rtl/core/cgbu_checker.sv @@
// Port-level checks of the graph update core, bound to its top level.
// Depends on cgbu_pkg and csr_graph_batch_update_core_assert.svh.
`include "csr_graph_batch_update_core_assert.svh"

module cgbu_checker
    import cgbu_pkg::*;
#(
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] status;
    logic                found;

    assign found  = m_axis_tdata[0];
    assign status = m_axis_tdata[STATUS_W:1];

    // Only defined status codes leave the block
    `CGBU_ASSERT_IMPLY(a_status_code, clk, rst_n, m_axis_tvalid, (status == STATUS_OK) || (status == STATUS_FULL) || (status == STATUS_OVERFLOW))

    // A hit is never reported together with an error
    `CGBU_ASSERT_IMPLY(a_found_ok, clk, rst_n, m_axis_tvalid && found, status == STATUS_OK)

    // Edge count stays within the store
    `CGBU_ASSERT_IMPLY(a_total_bound, clk, rst_n, m_axis_tvalid, 32'(m_axis_tdata[TOTAL_W+STATUS_W:STATUS_W+1]) <= MAX_EDGES)

    // One request at a time: intake closes right after an accept
    `CGBU_ASSERT_NEXT(a_one_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Stalled result holds
    `CGBU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind csr_graph_batch_update_core cgbu_checker #(
    .MAX_EDGES (MAX_EDGES)
) u_cgbu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
